### src/vcum_pkg.sv
// Shared types and constants for the value-channel unsharp mask.
package vcum_pkg;

    // Default build sizes
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int WFB_DEF       = 12;
    localparam int KERNEL_SIZE   = 5;

    // Frame height limits and counter widths
    localparam int MAX_HEIGHT = 2048;
    localparam int MIN_DIM    = 5;
    localparam int ROW_BITS   = 11;
    localparam int HGT_BITS   = 12;

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_AMOUNT       = 2'd2;
    localparam logic [11:0] RST_LINE_WIDTH   = 12'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [2:0]  RST_AMOUNT       = 3'd1;
    localparam logic [2:0]  MAX_AMOUNT       = 3'd5;

    // Item kinds
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_last;
    } t_out_item;

    // Color triple handed to the rescale divider
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

endpackage

### src/vcum_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module vcum_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [0:DEPTH-1];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### src/vcum_div.sv
// Three-lane restoring divider: out = (2*c*sharp + v) / (2*v), saturated at 255.
module vcum_div import vcum_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_v,
    input  logic [7:0] i_sharp,
    input  t_rgb       i_rgb,
    output logic       o_done,
    output t_rgb       o_rgb
);

    localparam int QB = 9;

    logic [3:0]    r_cnt;
    logic          r_busy;
    logic [8:0]    r_den;
    logic [8:0]    r_rem  [3];
    logic [QB-1:0] r_num  [3];
    logic [QB-1:0] r_quo  [3];
    logic [7:0]    chan   [3];
    logic [16:0]   num    [3];
    logic [9:0]    trial  [3];
    logic [7:0]    sat    [3];

    assign chan[0] = i_rgb.red;
    assign chan[1] = i_rgb.green;
    assign chan[2] = i_rgb.blue;

    // numerators and one quotient bit per lane
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num[k]   = 17'({1'b0, chan[k]} * {1'b0, i_sharp}) * 17'd2 + 17'(i_v);
            trial[k] = {r_rem[k], r_num[k][QB-1]};
            sat[k]   = (r_quo[k] > 9'd255) ? 8'd255 : r_quo[k][7:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(QB - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient stays below 2^9, so start with the top 8 numerator bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= {i_v, 1'b0};
            for (int k = 0; k < 3; k++) begin
                r_rem[k] <= {1'b0, num[k][16:9]};
                r_num[k] <= num[k][8:0];
                r_quo[k] <= '0;
            end
        end else if (r_busy) begin
            for (int k = 0; k < 3; k++) begin
                r_num[k] <= {r_num[k][QB-2:0], 1'b0};
                if (trial[k] >= {1'b0, r_den}) begin
                    r_rem[k] <= 9'(trial[k] - {1'b0, r_den});
                    r_quo[k] <= {r_quo[k][QB-2:0], 1'b1};
                end else begin
                    r_rem[k] <= trial[k][8:0];
                    r_quo[k] <= {r_quo[k][QB-2:0], 1'b0};
                end
            end
        end
    end

    assign o_rgb.red   = sat[0];
    assign o_rgb.green = sat[1];
    assign o_rgb.blue  = sat[2];

endmodule

### src/value_channel_unsharp_mask_core.sv
// Top level: value-channel unsharp mask over a five-row value store and three-row color store.
// An item that yields no result is taken without a stall. One that yields a result holds the
// input over 25 reads of the value memory (one port, one tap a cycle), a drain, a sharpen,
// a divider load, 9 divider steps, a divider done and an output load that waits out a stall.
// Reset restores the configuration defaults and clears the state, counters and output valid;
// memories, window and datapath registers and the output item are not cleared.
module value_channel_unsharp_mask_core import vcum_pkg::*; #(
    parameter int MAX_WIDTH            = MAX_WIDTH_DEF,
    parameter int WEIGHT_FRACTION_BITS = WFB_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    localparam int F      = WEIGHT_FRACTION_BITS;
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = ROW_BITS;
    localparam int HW     = HGT_BITS;
    localparam int PW     = WW + 2;
    localparam int VDEPTH = 5 * MAX_WIDTH;
    localparam int CDEPTH = 3 * MAX_WIDTH;
    localparam int VAW    = $clog2(VDEPTH);
    localparam int CAW    = $clog2(CDEPTH);
    localparam int ACCW   = F + 13;
    localparam int SW     = F + 18;
    localparam int KL     = KERNEL_SIZE - 1;

    // Gaussian weights, rounded half up
    localparam int WG_00 = (495 * (1 << F) + 5000) / 10000;
    localparam int WG_01 = (469 * (1 << F) + 5000) / 10000;
    localparam int WG_11 = (443 * (1 << F) + 5000) / 10000;
    localparam int WG_02 = (397 * (1 << F) + 5000) / 10000;
    localparam int WG_12 = (375 * (1 << F) + 5000) / 10000;
    localparam int WG_22 = (318 * (1 << F) + 5000) / 10000;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TAP   = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_SHARP = 3'd3;
    localparam logic [2:0] S_PREP  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]      r_state;
    logic [11:0]     r_line_width;
    logic [11:0]     r_frame_height;
    logic [2:0]      r_amount;
    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic [2:0]      r_vslot;
    logic [1:0]      r_cslot;
    logic [PW-1:0]   r_pend;
    logic [CW-1:0]   r_qc;
    logic [RW-1:0]   r_qr;
    logic [2:0]      r_qvs;
    logic [1:0]      r_qcs;
    logic [CW-1:0]   r_wc;
    logic [RW-1:0]   r_wr;
    logic [2:0]      r_wvs;
    logic [1:0]      r_wcs;
    logic            r_wlast;
    logic [2:0]      r_ty;
    logic [2:0]      r_tx;
    logic            r_tap_ok;
    logic            r_tap_ctr;
    logic            r_tap_first;
    logic [F-1:0]    r_tap_wgt;
    logic [ACCW-1:0] r_acc;
    logic [7:0]      r_v;
    t_rgb            r_rgb;
    logic [7:0]      r_sharp;
    logic            r_ovld;
    t_out_item       r_out;

    logic [31:0]     lw_ext;
    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;
    logic            in_acc;
    logic            is_pixel;
    logic [7:0]      pix_v;
    logic            p_zero;
    logic            p_emit;
    logic            col_wrap;
    logic            row_wrap;
    logic            q_wrap;
    logic            start;
    logic            geo_wr;
    logic [VAW-1:0]  v_waddr;
    logic [CAW-1:0]  c_waddr;
    logic [VAW-1:0]  v_raddr;
    logic [CAW-1:0]  c_raddr;
    logic [7:0]      v_rdata;
    t_rgb            c_rdata;
    t_rgb            pix_rgb;
    logic [RW+1:0]   ru;
    logic [CW+1:0]   cu;
    logic [CW-1:0]   cidx;
    logic [3:0]      ssum;
    logic [2:0]      tslot;
    logic            tap_ok;
    logic [1:0]      ay;
    logic [1:0]      ax;
    logic [F-1:0]    tap_wgt;
    logic [2:0]      amt;
    logic signed [SW-1:0] s_val;
    logic [7:0]      sharp;
    logic            div_done;
    t_rgb            div_rgb;

    // effective geometry
    always_comb begin
        lw_ext = 32'(r_line_width);
        if (lw_ext < 32'(MIN_DIM)) begin
            w_eff = WW'(MIN_DIM);
        end else if (lw_ext > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(lw_ext);
        end
        if (r_frame_height < HW'(MIN_DIM)) begin
            h_eff = HW'(MIN_DIM);
        end else if (r_frame_height > HW'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
    end

    // input side
    assign o_in_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign is_pixel = (i_in_item.mode == MODE_PIXEL);
    assign geo_wr   = i_cfg_valid && o_cfg_ready &&
                      (i_cfg_index == CFG_LINE_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT);

    always_comb begin
        pix_v = i_in_item.red;
        if (i_in_item.green > pix_v) pix_v = i_in_item.green;
        if (i_in_item.blue > pix_v) pix_v = i_in_item.blue;
    end

    assign pix_rgb.red   = i_in_item.red;
    assign pix_rgb.green = i_in_item.green;
    assign pix_rgb.blue  = i_in_item.blue;

    assign p_zero   = (r_row == '0) && (r_col == '0);
    assign p_emit   = (r_row > RW'(2)) || ((r_row == RW'(2)) && (r_col >= CW'(2)));
    assign col_wrap = (WW'(r_col) + WW'(1)) == w_eff;
    assign row_wrap = (HW'(r_row) + HW'(1)) == h_eff;
    assign q_wrap   = (WW'(r_qc) + WW'(1)) == w_eff;
    assign start    = in_acc && (is_pixel ? (p_emit && !p_zero) : (r_pend != '0));

    assign v_waddr = VAW'(int'(r_vslot) * MAX_WIDTH + int'(r_col));
    assign c_waddr = CAW'(int'(r_cslot) * MAX_WIDTH + int'(r_col));

    // tap address and bounds for the window walk
    always_comb begin
        ru     = (RW+2)'(r_wr) + (RW+2)'(r_ty);
        cu     = (CW+2)'(r_wc) + (CW+2)'(r_tx);
        cidx   = CW'(cu - (CW+2)'(2));
        tap_ok = (ru >= (RW+2)'(2)) && ((ru - (RW+2)'(2)) < (RW+2)'(h_eff)) &&
                 (cu >= (CW+2)'(2)) && ((cu - (CW+2)'(2)) < (CW+2)'(w_eff));
        ssum   = 4'(r_wvs) + 4'(r_ty) + 4'd3;
        if (ssum >= 4'd10) begin
            tslot = 3'(ssum - 4'd10);
        end else if (ssum >= 4'd5) begin
            tslot = 3'(ssum - 4'd5);
        end else begin
            tslot = 3'(ssum);
        end
        ay = (r_ty >= 3'd2) ? 2'(r_ty - 3'd2) : 2'(3'd2 - r_ty);
        ax = (r_tx >= 3'd2) ? 2'(r_tx - 3'd2) : 2'(3'd2 - r_tx);
    end

    assign v_raddr = VAW'(int'(tslot) * MAX_WIDTH + int'(cidx));
    assign c_raddr = CAW'(int'(r_wcs) * MAX_WIDTH + int'(r_wc));

    // weight by distance class
    always_comb begin
        case ({ay, ax})
            4'b0000: tap_wgt = F'(WG_00);
            4'b0001, 4'b0100: tap_wgt = F'(WG_01);
            4'b0101: tap_wgt = F'(WG_11);
            4'b0010, 4'b1000: tap_wgt = F'(WG_02);
            4'b0110, 4'b1001: tap_wgt = F'(WG_12);
            4'b1010: tap_wgt = F'(WG_22);
            default: tap_wgt = '0;
        endcase
    end

    // sharpen: V*(1+a)*2^F - acc*a, rounded and clamped
    always_comb begin
        amt   = (r_amount > MAX_AMOUNT) ? MAX_AMOUNT : r_amount;
        s_val = $signed((SW'(r_v) * SW'(amt + 3'd1)) << F) - $signed(SW'(r_acc) * SW'(amt))
                + $signed(SW'(1) << (F - 1));
        if (s_val[SW-1]) begin
            sharp = 8'd0;
        end else if (|s_val[SW-2:F+8]) begin
            sharp = 8'd255;
        end else begin
            sharp = s_val[F+7:F];
        end
    end

    vcum_ram #(.DW(8), .DEPTH(VDEPTH)) u_vram (
        .i_clk   (i_clk),
        .i_we    (in_acc && is_pixel),
        .i_waddr (v_waddr),
        .i_wdata (pix_v),
        .i_re    (r_state == S_TAP),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    vcum_ram #(.DW(24), .DEPTH(CDEPTH)) u_cram (
        .i_clk   (i_clk),
        .i_we    (in_acc && is_pixel),
        .i_waddr (c_waddr),
        .i_wdata (pix_rgb),
        .i_re    (r_state == S_TAP),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    vcum_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP),
        .i_v     (r_v),
        .i_sharp (r_sharp),
        .i_rgb   (r_rgb),
        .o_done  (div_done),
        .o_rgb   (div_rgb)
    );

    // configuration, position counters and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_line_width   <= RST_LINE_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_amount       <= RST_AMOUNT;
            r_col          <= '0;
            r_row          <= '0;
            r_vslot        <= '0;
            r_cslot        <= '0;
            r_pend         <= '0;
            r_qc           <= '0;
            r_qr           <= '0;
            r_qvs          <= '0;
            r_qcs          <= '0;
            r_ovld         <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    CFG_AMOUNT:       r_amount       <= i_cfg_data[2:0];
                    default: ;
                endcase
            end

            if (geo_wr) begin
                r_col   <= '0;
                r_row   <= '0;
                r_vslot <= '0;
                r_cslot <= '0;
                r_pend  <= '0;
                r_qc    <= '0;
                r_qr    <= '0;
                r_qvs   <= '0;
                r_qcs   <= '0;
            end else if (in_acc) begin
                if (is_pixel) begin
                    r_pend <= '0;
                    if (col_wrap) begin
                        r_col <= '0;
                        if (row_wrap) begin
                            r_row   <= '0;
                            r_vslot <= '0;
                            r_cslot <= '0;
                            r_pend  <= PW'({w_eff, 1'b0}) + PW'(2);
                        end else begin
                            r_row   <= r_row + RW'(1);
                            r_vslot <= (r_vslot == 3'd4) ? 3'd0 : r_vslot + 3'd1;
                            r_cslot <= (r_cslot == 2'd2) ? 2'd0 : r_cslot + 2'd1;
                        end
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                    if (p_zero) begin
                        r_qc  <= '0;
                        r_qr  <= '0;
                        r_qvs <= '0;
                        r_qcs <= '0;
                    end
                end else if (r_pend != '0) begin
                    r_pend <= r_pend - PW'(1);
                end
                // step the result position
                if (start) begin
                    if (q_wrap) begin
                        r_qc  <= '0;
                        r_qr  <= r_qr + RW'(1);
                        r_qvs <= (r_qvs == 3'd4) ? 3'd0 : r_qvs + 3'd1;
                        r_qcs <= (r_qcs == 2'd2) ? 2'd0 : r_qcs + 2'd1;
                    end else begin
                        r_qc <= r_qc + CW'(1);
                    end
                end
            end

            // output register
            if (r_state == S_OUT && (!r_ovld || !i_out_stall)) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (start) r_state <= S_TAP;
                end
                S_TAP: begin
                    if (r_tx == 3'(KL) && r_ty == 3'(KL)) r_state <= S_LAST;
                end
                S_LAST:  r_state <= S_SHARP;
                S_SHARP: r_state <= S_PREP;
                S_PREP:  r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovld || !i_out_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // window walk and accumulation
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_wc    <= r_qc;
            r_wr    <= r_qr;
            r_wvs   <= r_qvs;
            r_wcs   <= r_qcs;
            r_wlast <= !is_pixel && (r_pend == PW'(1));
            r_ty    <= '0;
            r_tx    <= '0;
            r_acc   <= '0;
        end else begin
            if (r_state == S_TAP) begin
                if (r_tx == 3'(KL)) begin
                    r_tx <= '0;
                    r_ty <= r_ty + 3'd1;
                end else begin
                    r_tx <= r_tx + 3'd1;
                end
            end
            if (r_tap_ok) begin
                r_acc <= r_acc + ACCW'(r_tap_wgt) * ACCW'(v_rdata);
            end
        end
        r_tap_ok    <= (r_state == S_TAP) && tap_ok;
        r_tap_ctr   <= (r_state == S_TAP) && (r_ty == 3'd2) && (r_tx == 3'd2);
        r_tap_first <= (r_state == S_TAP) && (r_ty == 3'd0) && (r_tx == 3'd0);
        r_tap_wgt   <= tap_wgt;
        if (r_tap_ctr) r_v <= v_rdata;
        if (r_tap_first) r_rgb <= c_rdata;
        if (r_state == S_SHARP) r_sharp <= sharp;
        if (r_state == S_OUT && (!r_ovld || !i_out_stall)) begin
            r_out.out_red    <= (r_v == 8'd0) ? r_sharp : div_rgb.red;
            r_out.out_green  <= (r_v == 8'd0) ? r_sharp : div_rgb.green;
            r_out.out_blue   <= (r_v == 8'd0) ? r_sharp : div_rgb.blue;
            r_out.frame_last <= r_wlast;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_item  = r_out;

endmodule

### sim/tb.sv
// Self-checking testbench for the value-channel unsharp mask core.
`timescale 1ns / 100ps

module tb;
    import vcum_pkg::*;

    localparam int VAL_DEPTH = 4 * MAX_WIDTH_DEF + 8;
    localparam int COL_DEPTH = 2 * MAX_WIDTH_DEF + 4;
    localparam int WFB       = WFB_DEF;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_item  o_out_item;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = CFG_LINE_WIDTH;
    logic [11:0] i_cfg_data = '0;

    value_channel_unsharp_mask_core u_top (.*);

    // Clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Predictor state
    logic [11:0] px_width  = RST_LINE_WIDTH;
    logic [11:0] px_height = RST_FRAME_HEIGHT;
    logic [2:0]  strength  = RST_AMOUNT;
    logic [7:0]  value_ring [VAL_DEPTH];
    logic [23:0] color_ring [COL_DEPTH];
    int unsigned col_pos = 0, row_pos = 0, owed = 0;

    t_in_item  pixel_q [$];
    t_out_item enhanced_q [$];
    int        errors = 0;
    int        send_idle_pct = 0, recv_idle_pct = 0;
    int        hold_seq = 0, hold_seen = 0, hold_left = 0;
    logic      in_fire = 1'b0;

    function automatic int unsigned eff_w();
        return px_width < 5 ? 5 : (px_width > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : px_width);
    endfunction

    function automatic int unsigned eff_h();
        return px_height < 5 ? 5 : (px_height > MAX_HEIGHT ? MAX_HEIGHT : px_height);
    endfunction

    // Gaussian tap weight, rounded to WFB fraction bits
    function automatic longint gauss_w(int dy, int dx);
        int coef [3][3];
        int ay, ax;
        coef = '{'{495, 469, 397}, '{469, 443, 375}, '{397, 375, 318}};
        ay = dy < 0 ? -dy : dy;
        ax = dx < 0 ? -dx : dx;
        return (longint'(coef[ay][ax]) * (longint'(1) << WFB) + 5000) / 10000;
    endfunction

    // Sharpened, rescaled pixel at frame position q
    function automatic t_out_item enhance_at(int unsigned q, int unsigned w, int unsigned h,
                                             bit last);
        t_out_item   res;
        int          r, c, rr, cc;
        longint      acc, s;
        int unsigned a, v, sharp, o;
        logic [23:0] rgb;
        logic [7:0]  ch [3];
        r = q / w;
        c = q % w;
        acc = 0;
        a = strength > MAX_AMOUNT ? MAX_AMOUNT : strength;
        v = value_ring[q % VAL_DEPTH];
        rgb = color_ring[q % COL_DEPTH];
        for (int dy = -2; dy <= 2; dy++) begin
            for (int dx = -2; dx <= 2; dx++) begin
                rr = r + dy;
                cc = c + dx;
                if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w))
                    acc += gauss_w(dy, dx) * value_ring[(rr * w + cc) % VAL_DEPTH];
            end
        end
        s = longint'(v) * (1 + a) * (longint'(1) << WFB) - acc * a
            + (longint'(1) << (WFB - 1));
        if (s < 0) sharp = 0;
        else sharp = (s >>> WFB) > 255 ? 255 : int'(s >>> WFB);
        ch = '{rgb[23:16], rgb[15:8], rgb[7:0]};
        for (int k = 0; k < 3; k++) begin
            if (v == 0) o = sharp;
            else o = (2 * ch[k] * sharp + v) / (2 * v);
            ch[k] = o > 255 ? 8'd255 : o[7:0];
        end
        res.out_red = ch[0];
        res.out_green = ch[1];
        res.out_blue = ch[2];
        res.frame_last = last;
        return res;
    endfunction

    // Advance the predictor by one accepted item; queue a result if one is due
    function automatic void predict_item(t_in_item it);
        int unsigned w, h, lag, v, p;
        w = eff_w();
        h = eff_h();
        lag = 2 * w + 2;
        if (it.mode == MODE_PIXEL) begin
            v = it.red;
            if (it.green > v) v = it.green;
            if (it.blue > v) v = it.blue;
            if (col_pos >= w) col_pos = 0;
            if (row_pos >= h) row_pos = 0;
            owed = 0;
            p = row_pos * w + col_pos;
            value_ring[p % VAL_DEPTH] = v[7:0];
            color_ring[p % COL_DEPTH] = {it.red, it.green, it.blue};
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h) begin
                    row_pos = 0;
                    owed = lag;
                end
            end
            if (p >= lag) enhanced_q.push_back(enhance_at(p - lag, w, h, 1'b0));
        end else if (owed == 0 || owed > w * h) begin
            owed = 0;
        end else begin
            p = w * h - owed;
            owed--;
            enhanced_q.push_back(enhance_at(p, w, h, owed == 0));
        end
    endfunction

    function automatic void apply_cfg(logic [1:0] idx, logic [11:0] data);
        case (idx)
            CFG_LINE_WIDTH: begin
                px_width = data;
            end
            CFG_FRAME_HEIGHT: begin
                px_height = data;
            end
            CFG_AMOUNT: begin
                strength = data[2:0];
                return;
            end
            default: return;
        endcase
        col_pos = 0;
        row_pos = 0;
        owed = 0;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Monitor: prediction on input accept, checking on output accept
    always @(posedge i_clk) begin
        t_out_item want;
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) apply_cfg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) predict_item(i_in_item);
            if (o_out_valid && !i_out_stall) begin
                if (enhanced_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = enhanced_q.pop_front();
                    if (o_out_item.out_red !== want.out_red)
                        report_mismatch("out_red", o_out_item.out_red, want.out_red);
                    if (o_out_item.out_green !== want.out_green)
                        report_mismatch("out_green", o_out_item.out_green, want.out_green);
                    if (o_out_item.out_blue !== want.out_blue)
                        report_mismatch("out_blue", o_out_item.out_blue, want.out_blue);
                    if (o_out_item.frame_last !== want.frame_last)
                        report_mismatch("frame_last", o_out_item.frame_last, want.frame_last);
                end
            end
        end
    end

    // Driver: holds a stalled item, otherwise offers the next one or idles
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fire) begin
            i_in_valid <= 1'b1;
        end else if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            i_in_item <= pixel_q.pop_front();
            i_in_valid <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver stall, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= 400;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= $urandom_range(99) < recv_idle_pct;
        end
    end

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pixel_q.size() != 0 || (i_in_valid && !in_fire) || enhanced_q.size() != 0);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [11:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_in_item it;
        it.mode = MODE_PIXEL;
        it.red = r;
        it.green = g;
        it.blue = b;
        return it;
    endfunction

    function automatic t_in_item flush_tick();
        t_in_item it;
        it.mode = MODE_FLUSH;
        it.red = 8'($urandom);
        it.green = 8'($urandom);
        it.blue = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item rand_pixel();
        case ($urandom_range(9))
            0: return make_pixel(8'd0, 8'd0, 8'd0);
            1: return make_pixel(8'd255, 8'd255, 8'd255);
            2: return make_pixel(8'($urandom_range(7)), 8'($urandom_range(7)),
                                 8'($urandom_range(7)));
            default: return make_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        endcase
    endfunction

    // One frame of pixels, then its drain; some frames cut short or padded with noise
    task automatic queue_frame(int unsigned w, int unsigned h);
        int unsigned n_pix, n_flush;
        n_pix = w * h;
        n_flush = 2 * w + 2;
        case ($urandom_range(9))
            0: n_pix = $urandom_range(w * h - 1, 1);
            1: n_flush = $urandom_range(n_flush - 1);
            2: n_flush += $urandom_range(3, 1);
            default: ;
        endcase
        for (int i = 0; i < n_pix; i++) begin
            if ($urandom_range(29) == 0) pixel_q.push_back(flush_tick());
            pixel_q.push_back(rand_pixel());
        end
        for (int i = 0; i < n_flush; i++) pixel_q.push_back(flush_tick());
    endtask

    task automatic set_geometry(logic [11:0] w, logic [11:0] h, logic [2:0] a);
        write_cfg(CFG_LINE_WIDTH, w);
        write_cfg(CFG_FRAME_HEIGHT, h);
        write_cfg(CFG_AMOUNT, {9'd0, a});
    endtask

    // Stimulus sequence
    initial begin
        int unsigned w, h, budget;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: smallest frame, strongest amount, color and black extremes
        set_geometry(12'd5, 12'd5, MAX_AMOUNT);
        write_cfg(CFG_UNUSED, 12'hFFF);
        pixel_q.push_back(flush_tick());
        pixel_q.push_back(make_pixel(8'd0, 8'd0, 8'd0));
        pixel_q.push_back(make_pixel(8'd255, 8'd255, 8'd255));
        pixel_q.push_back(make_pixel(8'd255, 8'd0, 8'd0));
        pixel_q.push_back(make_pixel(8'd0, 8'd255, 8'd0));
        pixel_q.push_back(make_pixel(8'd0, 8'd0, 8'd255));
        pixel_q.push_back(flush_tick());
        for (int i = 0; i < 20; i++)
            pixel_q.push_back(i % 3 == 0 ? make_pixel(8'd0, 8'd0, 8'd0)
                                         : make_pixel(8'd255, 8'd128, 8'd1));
        for (int i = 0; i < 13; i++) pixel_q.push_back(flush_tick());
        wait_drained();

        // Random phases under three idling patterns
        for (int m = 0; m < 3; m++) begin
            send_idle_pct = m == 0 ? 35 : (m == 1 ? 45 : 0);
            recv_idle_pct = m == 0 ? 45 : (m == 1 ? 35 : 0);
            budget = 0;
            while (budget < 140) begin
                w = $urandom_range(3) == 0 ? 0 : $urandom_range(8, 5);
                h = $urandom_range(3) == 0 ? 0 : $urandom_range(7, 5);
                set_geometry(12'(w), 12'(h), 3'($urandom_range(7)));
                if (w < 5) w = 5;
                if (h < 5) h = 5;
                for (int f = $urandom_range(2, 1); f > 0; f--) queue_frame(w, h);
                budget += pixel_q.size();
                if (m == 0 && hold_seq == 0) hold_seq++;
                wait_drained();
            end
        end

        // Register maxima: width clamps to the widest line, so a short stream stays silent
        set_geometry(12'hFFF, 12'd5, 3'd3);
        for (int i = 0; i < 40; i++) pixel_q.push_back(rand_pixel());
        for (int i = 0; i < 4; i++) pixel_q.push_back(flush_tick());
        wait_drained();
        set_geometry(12'd0, 12'hFFF, 3'd0);
        for (int i = 0; i < 40; i++) pixel_q.push_back(rand_pixel());
        wait_drained();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
